// ===== rtl/core/pol_pkg.sv =====
package pol_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== rtl/core/positional_ordered_list.sv =====
// Ordered list of up to DEPTH values, one command per request.
// Input channel (s_*): s_cmd selects insert at s_position, delete at
// s_position, or find s_value. Positions are 1-based; 0 acts as 1 and
// positions past the end are clamped to the tail.
// Result channel (m_*): one result per request with m_status, m_found,
// m_found_index and the entry count after the command.
// Entries live in a single-port-read, single-port-write memory with a
// registered read. Insert and delete move one entry per cycle through it;
// find compares one entry per cycle.
// Rejected or unknown requests, a find on an empty list and a delete of the
// last entry go straight to the result; an append writes the value directly
// (ST_PUT); other inserts shift (ST_SHIFT, ST_DRAIN) then write, other deletes
// shift then drain, and find scans until the first match or the last entry.
// One request is in flight at a time: s_ready is high only when the block
// is idle, so a new request is taken only after the last result is accepted.
// The result is held in registers until m_ready; the block stalls meanwhile.
// Reset (aresetn low, synchronous) empties the list at once; memory
// contents are left as they are and need no clearing pass.
module positional_ordered_list #(
    parameter int DEPTH      = pol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pol_pkg::CMD_W-1:0]            s_cmd,
    input  logic [pol_pkg::POS_W-1:0]            s_position,
    input  logic signed [DATA_WIDTH-1:0]         s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pol_pkg::STATUS_W-1:0]         m_status,
    output logic                                 m_found,
    output logic [pol_pkg::IDX_W-1:0]            m_found_index,
    output logic [pol_pkg::IDX_W-1:0]            m_count
);
    import pol_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SHIFT, ST_DRAIN, ST_PUT, ST_SCAN, ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0]   val_reg, val_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [AW-1:0]           end_reg, end_next;
    logic [AW-1:0]           tgt_reg, tgt_next;
    logic [AW-1:0]           last_reg, last_next;
    logic                    rvld_reg, rvld_next;
    logic                    issued_reg, issued_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    found_reg, found_next;
    logic [CW-1:0]           fidx_reg, fidx_next;

    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   mem_rdata_reg;
    logic                    mem_re, mem_we;
    logic [AW-1:0]           mem_raddr, mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;

    logic [PW-1:0]           pos_ext, cnt_ext, pos_ins, pos_del;
    logic                    is_ins;

    assign pos_ext = (s_position == '0) ? PW'(1) : PW'(s_position);
    assign cnt_ext = PW'(cnt_reg);
    assign pos_ins = (pos_ext > cnt_ext + PW'(1)) ? cnt_ext + PW'(1) : pos_ext;
    assign pos_del = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign is_ins  = (cmd_reg == CMD_INSERT);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        tgt_next    = tgt_reg;
        last_next   = last_reg;
        rvld_next   = 1'b0;
        issued_next = issued_reg;
        status_next = status_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_cmd;
                    val_next    = s_value;
                    issued_next = 1'b0;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    state_next  = ST_RESP;
                    case (s_cmd)
                        CMD_INSERT: begin
                            if (cnt_reg == CW'(DEPTH)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                tgt_next = AW'(pos_ins - PW'(1));
                                if (pos_ins == cnt_ext + PW'(1)) begin
                                    state_next = ST_PUT;
                                end else begin
                                    ptr_next   = AW'(cnt_reg - CW'(1));
                                    end_next   = AW'(pos_ins - PW'(1));
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (cnt_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else if (pos_del == cnt_ext) begin
                                cnt_next = cnt_reg - CW'(1);
                            end else begin
                                ptr_next   = AW'(pos_del);
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_FIND: begin
                            if (cnt_reg != '0) begin
                                ptr_next   = '0;
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                mem_re    = 1'b1;
                rvld_next = 1'b1;
                last_next = ptr_reg;
                if (ptr_reg == end_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    ptr_next = is_ins ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (is_ins) begin
                    state_next = ST_PUT;
                end else begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_PUT: begin
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                if (rvld_reg && mem_rdata_reg == val_reg) begin
                    found_next = 1'b1;
                    fidx_next  = CW'(last_reg) + CW'(1);
                    state_next = ST_RESP;
                end else if (rvld_reg && last_reg == end_reg) begin
                    state_next = ST_RESP;
                end else if (!issued_reg) begin
                    mem_re    = 1'b1;
                    rvld_next = 1'b1;
                    last_next = ptr_reg;
                    if (ptr_reg == end_reg) begin
                        issued_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shifted entries land one slot away from where they were read.
    assign mem_we    = (rvld_reg && (state_reg == ST_SHIFT || state_reg == ST_DRAIN))
                       || (state_reg == ST_PUT);
    assign mem_waddr = (state_reg == ST_PUT) ? tgt_reg
                     : (is_ins ? last_reg + AW'(1) : last_reg - AW'(1));
    assign mem_wdata = (state_reg == ST_PUT) ? val_reg : mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rvld_reg   <= 1'b0;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvld_reg   <= rvld_next;
            issued_reg <= issued_next;
        end
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        tgt_reg    <= tgt_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_RESP);
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_found_index = IDX_W'(fidx_reg);
    assign m_count       = IDX_W'(cnt_reg);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request accepted while a result is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT) |=> (m_valid && cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (fidx_reg != '0 && fidx_reg <= cnt_reg))
        else $error("found index outside the list");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("block did not return to idle after result");

endmodule

// ===== test/positional_ordered_list_tb.sv =====
`timescale 1ns / 100ps

module positional_ordered_list_tb;
    import pol_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = DEPTH + 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef logic [DATA_WIDTH-1:0] entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [IDX_W-1:0]    found_index;
        logic [IDX_W-1:0]    count;
    } list_result_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} workload_t;

    class list_scoreboard;
        entry_t       entries[$];
        list_result_t pending[$];
        int           errors;

        function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] position,
                                   entry_t value);
            list_result_t r;
            int           p;
            r = '0;
            p = (position == 0) ? 1 : int'(position);
            case (cmd)
                CMD_INSERT: begin
                    if (entries.size() >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        if (p > entries.size() + 1) p = entries.size() + 1;
                        entries.insert(p - 1, value);
                    end
                end
                CMD_DELETE: begin
                    if (entries.size() == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        if (p > entries.size()) p = entries.size();
                        entries.delete(p - 1);
                    end
                end
                CMD_FIND: begin
                    for (int i = 0; i < entries.size(); i++) begin
                        if (!r.found && entries[i] == value) begin
                            r.found       = 1'b1;
                            r.found_index = IDX_W'(i + 1);
                        end
                    end
                end
                default: ;
            endcase
            r.count = IDX_W'(entries.size());
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                errors++;
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(list_result_t act);
            list_result_t exp;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
                return;
            end
            exp = pending.pop_front();
            compare_field("status", exp.status, act.status);
            compare_field("found", exp.found, act.found);
            compare_field("found_index", exp.found_index, act.found_index);
            compare_field("count", exp.count, act.count);
        endfunction
    endclass

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic [CMD_W-1:0]             s_cmd      = '0;
    logic [POS_W-1:0]             s_position = '0;
    logic signed [DATA_WIDTH-1:0] s_value    = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic [STATUS_W-1:0]          m_status;
    logic                         m_found;
    logic [IDX_W-1:0]             m_found_index;
    logic [IDX_W-1:0]             m_count;

    list_scoreboard sb;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             cycles         = 0;
    int             phase_send[4]  = '{0, 68, 0, 25};
    int             phase_recv[4]  = '{0, 0, 68, 25};

    positional_ordered_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found       (m_found),
        .m_found_index (m_found_index),
        .m_count       (m_count)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL positional_ordered_list");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_status, m_found, m_found_index, m_count});
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] position,
                                entry_t value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= position;
        s_value    <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, position, value);
    endtask

    function automatic entry_t pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return entry_t'(int'($urandom_range(7)) - 4);
        if (sel == 4) begin
            case ($urandom_range(3))
                0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
                1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return entry_t'($urandom);
    endfunction

    task automatic random_request(workload_t mode);
        int               n;
        int               r;
        int               ins_pct;
        int               del_pct;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        entry_t           value;
        n       = sb.entries.size();
        r       = $urandom_range(99);
        ins_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 10 : 40;
        del_pct = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 75 : 35;
        if (r < 3) cmd = CMD_UNUSED;
        else if (r < 3 + ins_pct) cmd = CMD_INSERT;
        else if (r < 3 + ins_pct + del_pct) cmd = CMD_DELETE;
        else cmd = CMD_FIND;
        if ($urandom_range(9) == 0) position = POS_W'($urandom_range(127));
        else position = POS_W'($urandom_range(n + 2));
        value = pick_value();
        if (cmd == CMD_FIND && n > 0 && $urandom_range(1) == 0) begin
            value = sb.entries[$urandom_range(n - 1)];
        end
        send_request(cmd, position, value);
    endtask

    initial begin
        workload_t mode;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // corner cases on an empty list, clamping and first-match search
        send_request(CMD_DELETE, 7'd0, '0);
        send_request(CMD_FIND, 7'd1, '0);
        send_request(CMD_UNUSED, 7'd0, '0);
        send_request(CMD_INSERT, 7'd0, {1'b1, {(DATA_WIDTH-1){1'b0}}});
        send_request(CMD_INSERT, 7'd127, {1'b0, {(DATA_WIDTH-1){1'b1}}});
        send_request(CMD_INSERT, 7'd1, '0);
        send_request(CMD_INSERT, 7'd2, '1);
        send_request(CMD_INSERT, 7'd64, entry_t'(5));
        send_request(CMD_INSERT, 7'd6, '0);
        send_request(CMD_FIND, 7'd0, {1'b0, {(DATA_WIDTH-1){1'b1}}});
        send_request(CMD_FIND, 7'd127, entry_t'(5));
        send_request(CMD_FIND, 7'd3, '0);
        send_request(CMD_FIND, 7'd3, entry_t'(12345));
        send_request(CMD_UNUSED, 7'd127, '1);
        send_request(CMD_DELETE, 7'd0, '0);
        send_request(CMD_DELETE, 7'd127, '0);
        send_request(CMD_DELETE, 7'd2, '0);
        send_request(CMD_FIND, 7'd64, '1);

        for (int chunk = 0; chunk < 12; chunk++) begin
            send_idle_pct  = phase_send[chunk % 4];
            recv_stall_pct = phase_recv[chunk % 4];
            if (chunk == 0) mode = MODE_FILL;
            else if (chunk == 1) mode = MODE_DRAIN;
            else mode = workload_t'($urandom_range(2));
            repeat (100) random_request(mode);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS positional_ordered_list");
        end else begin
            $display("FAIL positional_ordered_list");
        end
        $finish;
    end

endmodule
